FILE: sv/prac_pkg.sv
// Shared types, constants and helpers for the paged range access checker.
package prac_pkg;

  // Address and page map geometry
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned DIR_SHIFT    = 22;
  localparam int unsigned TBL_SHIFT    = 12;
  localparam int unsigned DIR_ENTRIES  = 1024;
  localparam int unsigned TBL_ENTRIES  = 1024;
  localparam logic [IDX_W-1:0] IDX_MASK = 10'h3ff;

  // Walk pointer counts 4KB pages, one extra bit to catch a wrap past the top
  localparam int unsigned PAGE_W       = ADDR_W + 1 - TBL_SHIFT;
  localparam int unsigned BIG_LOW_W    = DIR_SHIFT - TBL_SHIFT;

  // Entry flag positions in a raw entry word
  localparam int unsigned BIT_PRESENT  = 0;
  localparam int unsigned BIT_WRITE    = 1;
  localparam int unsigned BIT_USER     = 2;
  localparam int unsigned BIT_BIG      = 7;

  // Stored flags: {big, user, write, present} for the directory,
  // {user, write, present} for the table
  localparam int unsigned DIR_FLAG_W   = 4;
  localparam int unsigned TBL_FLAG_W   = 3;

  // Request types
  localparam logic [1:0] REQ_DIR_WR    = 2'd0;
  localparam logic [1:0] REQ_TBL_WR    = 2'd1;
  localparam logic [1:0] REQ_CHECK     = 2'd2;

  typedef enum logic [2:0] {
    CAUSE_OK  = 3'd0,
    CAUSE_NEG = 3'd1,
    CAUSE_OVF = 3'd2,
    CAUSE_DIR = 3'd3,
    CAUSE_TBL = 3'd4
  } cause_e;

  typedef struct packed {
    logic   accessible;
    cause_e cause;
  } result_t;

  // Write and read controls toward the two entry stores
  typedef struct packed {
    logic                  dir_we;
    logic                  tbl_we;
    logic [IDX_W-1:0]      waddr;
    logic [DIR_FLAG_W-1:0] wdata;
    logic [IDX_W-1:0]      dir_raddr;
    logic [IDX_W-1:0]      tbl_raddr;
  } mem_req_t;

  // Present, and user/write allowed where asked; flags are {user, write, present}
  function automatic logic entry_ok(logic [TBL_FLAG_W-1:0] flags, logic user, logic write);
    entry_ok = flags[0] && (!user || flags[2]) && (!write || flags[1]);
  endfunction

endpackage

FILE: sv/prac_ram.sv
// Generic single write port, single read port RAM with registered read data.
module prac_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/prac_walk.sv
// Sequencer for the page walk: clearing pass, entry writes and range checks.
module prac_walk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           req_type_i,
  input  logic [prac_pkg::IDX_W-1:0]           entry_index_i,
  input  logic [prac_pkg::ADDR_W-1:0]          entry_word_i,
  input  logic [prac_pkg::ADDR_W-1:0]          start_addr_i,
  input  logic signed [prac_pkg::ADDR_W-1:0]   byte_count_i,
  input  logic                                 user_access_i,
  input  logic                                 write_access_i,
  input  logic [prac_pkg::DIR_FLAG_W-1:0]      dir_rdata_i,
  input  logic [prac_pkg::TBL_FLAG_W-1:0]      tbl_rdata_i,
  output prac_pkg::mem_req_t                   mem_o,
  output logic                                 res_valid_o,
  input  logic                                 res_taken_i,
  output prac_pkg::result_t                    res_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_CMP    = 6'b000100,
    ST_DIR    = 6'b001000,
    ST_TBL    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e                         state_q, state_d;
  logic [prac_pkg::IDX_W-1:0]     clr_q, clr_d;
  logic [prac_pkg::ADDR_W:0]      addr_q, addr_d;
  logic [prac_pkg::ADDR_W-1:0]    end_q, end_d;
  logic                           user_q, user_d;
  logic                           write_q, write_d;
  prac_pkg::result_t              res_q, res_d;

  logic [prac_pkg::ADDR_W:0]      range_end;
  logic                           big_step;
  logic [prac_pkg::PAGE_W-1:0]    page_inc;
  logic [prac_pkg::ADDR_W:0]      step_addr;
  logic [prac_pkg::DIR_FLAG_W-1:0] in_flags;

  // Range end, computed once at accept
  assign range_end = {1'b0, start_addr_i} + {1'b0, byte_count_i};

  assign in_flags = {entry_word_i[prac_pkg::BIT_BIG], entry_word_i[prac_pkg::BIT_USER],
                     entry_word_i[prac_pkg::BIT_WRITE], entry_word_i[prac_pkg::BIT_PRESENT]};

  // Shared page stepper: next 4KB boundary, or next 4MB boundary for a big entry
  assign big_step = (state_q == ST_DIR);
  assign page_inc = addr_q[prac_pkg::ADDR_W:prac_pkg::TBL_SHIFT]
                  + (big_step ? prac_pkg::PAGE_W'(1) << prac_pkg::BIG_LOW_W
                              : prac_pkg::PAGE_W'(1));
  assign step_addr = {page_inc[prac_pkg::PAGE_W-1:prac_pkg::BIG_LOW_W],
                      big_step ? {prac_pkg::BIG_LOW_W{1'b0}}
                               : page_inc[prac_pkg::BIG_LOW_W-1:0],
                      {prac_pkg::TBL_SHIFT{1'b0}}};

  // Next state and datapath
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    addr_d  = addr_q;
    end_d   = end_q;
    user_d  = user_q;
    write_d = write_q;
    res_d   = res_q;

    mem_o           = '0;
    mem_o.dir_raddr = addr_q[prac_pkg::DIR_SHIFT +: prac_pkg::IDX_W] & prac_pkg::IDX_MASK;
    mem_o.tbl_raddr = addr_q[prac_pkg::TBL_SHIFT +: prac_pkg::IDX_W] & prac_pkg::IDX_MASK;

    case (state_q)
      ST_CLEAR: begin
        mem_o.dir_we = 1'b1;
        mem_o.tbl_we = 1'b1;
        mem_o.waddr  = clr_q;
        clr_d        = clr_q + 1'b1;
        if (clr_q == prac_pkg::IDX_MASK) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_FINISH;
          user_d  = user_access_i;
          write_d = write_access_i;
          case (req_type_i)
            prac_pkg::REQ_DIR_WR: begin
              mem_o.dir_we = 1'b1;
              mem_o.waddr  = entry_index_i;
              mem_o.wdata  = in_flags;
              res_d        = '{accessible: 1'b1, cause: prac_pkg::CAUSE_OK};
            end
            prac_pkg::REQ_TBL_WR: begin
              mem_o.tbl_we = 1'b1;
              mem_o.waddr  = entry_index_i;
              mem_o.wdata  = in_flags;
              res_d        = '{accessible: 1'b1, cause: prac_pkg::CAUSE_OK};
            end
            prac_pkg::REQ_CHECK: begin
              if (byte_count_i[prac_pkg::ADDR_W-1]) begin
                res_d = '{accessible: 1'b0, cause: prac_pkg::CAUSE_NEG};
              end else if (range_end[prac_pkg::ADDR_W]) begin
                res_d = '{accessible: 1'b0, cause: prac_pkg::CAUSE_OVF};
              end else begin
                addr_d  = {1'b0, start_addr_i};
                end_d   = range_end[prac_pkg::ADDR_W-1:0];
                state_d = ST_CMP;
              end
            end
            default: begin
              res_d = '{accessible: 1'b0, cause: prac_pkg::CAUSE_OK};
            end
          endcase
        end
      end

      // Range done? Otherwise the directory read is issued this cycle
      ST_CMP: begin
        if (addr_q >= {1'b0, end_q}) begin
          res_d   = '{accessible: 1'b1, cause: prac_pkg::CAUSE_OK};
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DIR;
        end
      end

      // Directory entry check; table read issued this cycle for a 4KB entry
      ST_DIR: begin
        if (!prac_pkg::entry_ok(dir_rdata_i[prac_pkg::TBL_FLAG_W-1:0], user_q, write_q)) begin
          res_d   = '{accessible: 1'b0, cause: prac_pkg::CAUSE_DIR};
          state_d = ST_FINISH;
        end else if (dir_rdata_i[prac_pkg::DIR_FLAG_W-1]) begin
          addr_d  = step_addr;
          state_d = ST_CMP;
        end else begin
          state_d = ST_TBL;
        end
      end

      ST_TBL: begin
        if (!prac_pkg::entry_ok(tbl_rdata_i, user_q, write_q)) begin
          res_d   = '{accessible: 1'b0, cause: prac_pkg::CAUSE_TBL};
          state_d = ST_FINISH;
        end else begin
          addr_d  = step_addr;
          state_d = ST_CMP;
        end
      end

      ST_FINISH: begin
        if (res_taken_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Walk payload
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    end_q   <= end_d;
    user_q  <= user_d;
    write_q <= write_d;
    res_q   <= res_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_FINISH);
  assign res_o       = res_q;

endmodule

FILE: sv/paged_range_access_checker.sv
// Sequence: an entry write goes to finish after accept; a range check visits compare,
// directory and table per 4KB page, compare and directory per 4MB page; a denial ends it.
// Throughput: one request at a time; the next is taken once the result reaches the
// output register, which may still be waiting on the consumer.
// Reset: both stores go through a clearing pass (one entry per cycle, through the RAM write
// port) during which no request is taken.
module paged_range_access_checker #(
  parameter int unsigned DirEntries = prac_pkg::DIR_ENTRIES,
  parameter int unsigned TblEntries = prac_pkg::TBL_ENTRIES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         req_type_i,
  input  logic [prac_pkg::IDX_W-1:0]         entry_index_i,
  input  logic [prac_pkg::ADDR_W-1:0]        entry_word_i,
  input  logic [prac_pkg::ADDR_W-1:0]        start_addr_i,
  input  logic signed [prac_pkg::ADDR_W-1:0] byte_count_i,
  input  logic                               user_access_i,
  input  logic                               write_access_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               accessible_o,
  output logic [2:0]                         fail_cause_o
);

  prac_pkg::mem_req_t                  mem_req;
  logic [prac_pkg::DIR_FLAG_W-1:0]     dir_rdata;
  logic [prac_pkg::TBL_FLAG_W-1:0]     tbl_rdata;
  logic                                res_valid;
  logic                                res_taken;
  prac_pkg::result_t                   res;

  logic                                out_valid_q;
  logic                                accessible_q;
  logic [2:0]                          fail_cause_q;

  // Directory store: {big, user, write, present}
  prac_ram #(
    .Width (prac_pkg::DIR_FLAG_W),
    .Depth (DirEntries)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.dir_we),
    .waddr_i (mem_req.waddr[$clog2(DirEntries)-1:0]),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.dir_raddr[$clog2(DirEntries)-1:0]),
    .rdata_o (dir_rdata)
  );

  // Table store: {user, write, present}
  prac_ram #(
    .Width (prac_pkg::TBL_FLAG_W),
    .Depth (TblEntries)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.tbl_we),
    .waddr_i (mem_req.waddr[$clog2(TblEntries)-1:0]),
    .wdata_i (mem_req.wdata[prac_pkg::TBL_FLAG_W-1:0]),
    .raddr_i (mem_req.tbl_raddr[$clog2(TblEntries)-1:0]),
    .rdata_o (tbl_rdata)
  );

  prac_walk u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .entry_word_i   (entry_word_i),
    .start_addr_i   (start_addr_i),
    .byte_count_i   (byte_count_i),
    .user_access_i  (user_access_i),
    .write_access_i (write_access_i),
    .dir_rdata_i    (dir_rdata),
    .tbl_rdata_i    (tbl_rdata),
    .mem_o          (mem_req),
    .res_valid_o    (res_valid),
    .res_taken_i    (res_taken),
    .res_o          (res)
  );

  // Output register loads when empty or being drained
  assign res_taken = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_taken) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      accessible_q <= res.accessible;
      fail_cause_q <= res.cause;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accessible_o = accessible_q;
  assign fail_cause_o = fail_cause_q;

endmodule
